// File: rtl/pss_pkg.sv
// ============================================================================
// pss_pkg
// Shared types and constants of the plucked-string synthesizer.
// ============================================================================
package pss_pkg;

    localparam int OPCODE_W = 2;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 32;
    localparam int DELAY_W  = 13;
    localparam int DECAY_W  = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // input opcodes
    localparam logic [OPCODE_W-1:0] OPC_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_LOAD  = 2'd2;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_DELAY_LENGTH = 1'b0;
    localparam logic REG_DECAY_Q16    = 1'b1;

    localparam logic [DELAY_W-1:0] DELAY_LENGTH_RESET = 13'd100;
    localparam logic [DECAY_W-1:0] DECAY_Q16_RESET    = 16'd65274;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CLEAR,
        OP_LOAD,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t                    kind;
        logic signed [SAMPLE_W-1:0]  load_value;
    } queue_entry_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_length;
        logic [DECAY_W-1:0] decay_q16;
    } cfg_t;

endpackage

// File: rtl/pss_if.sv
// ============================================================================
// pss_item_if / pss_result_if
// Valid/ready channels carrying input items and result items.
// ============================================================================
interface pss_item_if;
    import pss_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [OPCODE_W-1:0]         opcode;
    logic signed [SAMPLE_W-1:0]  load_value;

    modport source (output valid, output opcode, output load_value, input ready);
    modport sink   (input valid, input opcode, input load_value, output ready);
endinterface

interface pss_result_if;
    import pss_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic [COUNT_W-1:0]          tick_count;
    logic                        status;

    modport source (output valid, output sample_out, output tick_count, output status,
                    input ready);
    modport sink   (input valid, input sample_out, input tick_count, input status,
                    output ready);
endinterface

// File: rtl/pss_front.sv
// ============================================================================
// pss_front
// Accept item beats, decode the opcode and hold them in a two-entry queue.
// ============================================================================
module pss_front (
    input  logic                 clk,
    input  logic                 rst_n,
    pss_item_if.sink             item,
    output logic                 q_valid,
    output pss_pkg::queue_entry_t q_entry,
    input  logic                 q_pop
);
    import pss_pkg::*;

    queue_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg;
    logic [QPTR_W-1:0]         wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg;
    logic [QPTR_W-1:0]         rd_ptr_next;
    logic [QPTR_W:0]           count_reg;
    logic [QPTR_W:0]           count_next;
    logic                      push;
    queue_entry_t              decoded;

    assign item.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign q_valid    = (count_reg != '0);
    assign q_entry    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case (item.opcode)
            OPC_TICK:  decoded.kind = OP_TICK;
            OPC_CLEAR: decoded.kind = OP_CLEAR;
            OPC_LOAD:  decoded.kind = OP_LOAD;
            default:   decoded.kind = OP_NOP;
        endcase
        decoded.load_value = item.load_value;
    end

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// File: rtl/pss_back.sv
// ============================================================================
// pss_back
// Execute queued items on the delay ring and register the result beat.
// ============================================================================
module pss_back #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pss_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    input  pss_pkg::queue_entry_t q_entry,
    output logic                  q_pop,
    pss_result_if.source          result
);
    import pss_pkg::*;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int LEN_W  = (FILL_W > DELAY_W) ? FILL_W : DELAY_W;
    localparam int INIT_RAW  = int'(DELAY_LENGTH_RESET);
    localparam int INIT_FILL = (INIT_RAW > RING_DEPTH) ? RING_DEPTH :
                               ((INIT_RAW < 2) ? 2 : INIT_RAW);
    localparam int INIT_W = $clog2(INIT_FILL + 1);

    // ring memory, one write and one registered read per cycle
    logic [SAMPLE_W-1:0]          ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0]          rdata_reg;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [SAMPLE_W-1:0]          mem_wdata;
    logic                         mem_re;
    logic [IDX_W-1:0]             mem_raddr;

    logic [IDX_W-1:0]             head_reg,      head_next;
    logic [FILL_W-1:0]            fill_reg,      fill_next;
    logic [COUNT_W-1:0]           tick_reg,      tick_next;
    logic [INIT_W-1:0]            init_reg,      init_next;
    logic signed [SAMPLE_W-1:0]   front_reg,     front_next;
    logic signed [SAMPLE_W-1:0]   second_reg,    second_next;
    logic                         sec_mem_reg,   sec_mem_next;
    logic                         sec_zero_reg,  sec_zero_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]   sample_reg,    sample_next;
    logic                         status_reg,    status_next;

    logic                         fire;
    logic [LEN_W-1:0]             dl_ext;
    logic [LEN_W-1:0]             ring_len;
    logic                         ring_full;
    logic signed [SAMPLE_W-1:0]   second_val;
    logic signed [SAMPLE_W-1:0]   damped;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [FILL_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offset);
        if (sum >= SUM_W'(RING_DEPTH))
        begin
            sum = sum - SUM_W'(RING_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // trunc((a+b)*decay/2^17), rounding toward zero
    function automatic logic signed [SAMPLE_W-1:0] damp(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [DECAY_W-1:0]         decay
    );
        logic signed [SAMPLE_W:0]          sum;
        logic [SAMPLE_W:0]                 mag;
        logic [SAMPLE_W+DECAY_W:0]         prod;
        logic [SAMPLE_W-1:0]               v;
        sum  = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
        mag  = sum[SAMPLE_W] ? (SAMPLE_W+1)'(-sum) : (SAMPLE_W+1)'(sum);
        prod = (SAMPLE_W+DECAY_W+1)'(mag) * (SAMPLE_W+DECAY_W+1)'(decay);
        v    = prod[SAMPLE_W+DECAY_W:DECAY_W+1];
        return sum[SAMPLE_W] ? -$signed(v) : $signed(v);
    endfunction

    assign fire  = q_valid && (!out_valid_reg || result.ready);
    assign q_pop = fire;

    assign dl_ext     = LEN_W'(cfg.delay_length);
    assign ring_len   = (dl_ext < LEN_W'(2)) ? LEN_W'(2) :
                        ((dl_ext > LEN_W'(RING_DEPTH)) ? LEN_W'(RING_DEPTH) : dl_ext);
    assign ring_full  = (LEN_W'(fill_reg) >= ring_len);
    // entries still inside the reset region read as zero
    assign second_val = sec_mem_reg ? (sec_zero_reg ? '0 : $signed(rdata_reg)) : second_reg;
    assign damped     = damp(front_reg, second_val, cfg.decay_q16);

    always_comb
    begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        tick_next     = tick_reg;
        init_next     = init_reg;
        front_next    = front_reg;
        second_next   = second_reg;
        sec_mem_next  = sec_mem_reg;
        sec_zero_next = sec_zero_reg;
        status_next   = STATUS_OK;
        mem_we        = 1'b0;
        mem_waddr     = slot_of(head_reg, fill_reg);
        mem_wdata     = q_entry.load_value;
        mem_re        = 1'b0;
        mem_raddr     = slot_of(head_reg, FILL_W'(2));

        if (fire)
        begin
            case (q_entry.kind)
                OP_TICK:
                begin
                    if (!ring_full)
                    begin
                        status_next = STATUS_ERR;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = damped;
                        head_next  = slot_of(head_reg, FILL_W'(1));
                        tick_next  = tick_reg + 1'b1;
                        front_next = second_val;
                        init_next  = (init_reg != '0) ? init_reg - 1'b1 : init_reg;
                        if (fill_reg == FILL_W'(2))
                        begin
                            // new second entry is the value written right now
                            second_next  = damped;
                            sec_mem_next = 1'b0;
                        end
                        else
                        begin
                            mem_re        = 1'b1;
                            sec_mem_next  = 1'b1;
                            sec_zero_next = (init_reg > INIT_W'(2));
                        end
                    end
                end
                OP_CLEAR:
                begin
                    fill_next = '0;
                    init_next = '0;
                end
                OP_LOAD:
                begin
                    if (ring_full)
                    begin
                        status_next = STATUS_ERR;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == '0)
                        begin
                            front_next = q_entry.load_value;
                        end
                        else if (fill_reg == FILL_W'(1))
                        begin
                            second_next  = q_entry.load_value;
                            sec_mem_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        sample_next    = (fill_next == '0) ? '0 : front_next;
        out_valid_next = fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= FILL_W'(INIT_FILL);
            tick_reg      <= '0;
            init_reg      <= INIT_W'(INIT_FILL);
            front_reg     <= '0;
            second_reg    <= '0;
            sec_mem_reg   <= 1'b0;
            sec_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            tick_reg      <= tick_next;
            init_reg      <= init_next;
            front_reg     <= front_next;
            second_reg    <= second_next;
            sec_mem_reg   <= sec_mem_next;
            sec_zero_reg  <= sec_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_reg <= sample_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= ring_mem[mem_raddr];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = sample_reg;
    assign result.tick_count = tick_reg;
    assign result.status     = status_reg;

endmodule

// File: rtl/plucked_string_synth.sv
// ============================================================================
// plucked_string_synth
// Karplus-Strong plucked-string generator on a configurable delay ring.
// ============================================================================
// Each item (tick, clear, load or no-op) returns one result beat. The block
// sustains one item per clock while results are taken: the front decodes
// beats into a two-entry queue, and the back executes one queued item per
// cycle unless the result beat stalls, against a ring memory with one write
// port and one registered read port. The front and next-front samples are
// cached in registers, so a tick needs only the read of the entry two ahead.
// An accepted item is queued, and its result beat is registered when the back
// executes it. While a result beat waits in the output register, the queue
// still takes up to two more item beats before item ready drops. There is no
// clearing pass after reset: the ring holds min(100, RING_DEPTH) zero samples,
// tracked by a counter instead of by memory contents, so items are taken from
// the first cycle out of reset. Write delay_length and decay_q16 through the
// APB port only while no item is in flight.
// ============================================================================
module plucked_string_synth #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    pss_item_if.sink                     item,
    pss_result_if.source                 result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pss_pkg::APB_AW-1:0]   paddr,
    input  logic [pss_pkg::APB_DW-1:0]   pwdata,
    output logic [pss_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import pss_pkg::*;

    // configuration registers
    logic [DELAY_W-1:0]   delay_length_reg;
    logic [DECAY_W-1:0]   decay_q16_reg;
    logic                 cfg_write;
    cfg_t                 cfg;

    // queue between front and back
    logic                 q_valid;
    logic                 q_pop;
    queue_entry_t         q_entry;

    // write on the access phase; no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= DELAY_LENGTH_RESET;
            decay_q16_reg    <= DECAY_Q16_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_DELAY_LENGTH: delay_length_reg <= pwdata[DELAY_W-1:0];
                REG_DECAY_Q16:    decay_q16_reg    <= pwdata[DECAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back the addressed register, zero-extended
    always_comb
    begin
        case (paddr[2])
            REG_DELAY_LENGTH: prdata = APB_DW'(delay_length_reg);
            REG_DECAY_Q16:    prdata = APB_DW'(decay_q16_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.delay_length = delay_length_reg;
    assign cfg.decay_q16    = decay_q16_reg;

    // front: take beats and decode opcodes into the queue
    pss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    // back: advance the ring and register the result beat
    pss_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// File: rtl/pss_checker.sv
// ============================================================================
// pss_checker
// Port-level checks of the plucked-string synthesizer, bound to the top level.
// ============================================================================
module pss_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [15:0] result_sample_out,
    input  logic [31:0] result_tick_count,
    input  logic        result_status
);
    logic [31:0] last_tick_reg;
    logic        result_beat;

    assign result_beat = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tick_reg <= '0;
        end
        else if (result_beat)
        begin
            last_tick_reg <= result_tick_count;
        end
    end

    // a stalled result beat holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_sample_out) && $stable(result_tick_count)
            && $stable(result_status))
        else $error("result beat changed while stalled");

    // each item advances the tick count by at most one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_beat |->
            (result_tick_count == last_tick_reg) ||
            (result_tick_count == last_tick_reg + 32'd1))
        else $error("tick count jumped");

    // a rejected item leaves the tick count alone
    a_err_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result_beat && result_status |-> result_tick_count == last_tick_reg)
        else $error("failed item counted a tick");

    // input back-pressure only follows a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |-> $past(result_valid && !result_ready))
        else $error("input stalled without output back-pressure");

endmodule

bind plucked_string_synth pss_checker u_pss_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_sample_out (result.sample_out),
    .result_tick_count (result.tick_count),
    .result_status     (result.status)
);
